>>> src/pcs_pkg.sv
// Package for the PI clock servo: field widths, mode/method/register codes
// and the shared clamp and limit-check helpers. No dependencies.
`default_nettype none
package pcs_pkg;

	localparam int OFF_W  = 32;
	localparam int TIME_W = 32;
	localparam int GAIN_W = 32;
	localparam int LIM_W  = 47;
	localparam int VAL_W  = 48;
	localparam int PROD_W = 96;
	localparam int STEP_W = 50;
	localparam int WIDE_W = 58;
	localparam int TCAP_W = 8;
	localparam int CFG_AW = 3;

	localparam logic [1:0] MODE_FEED  = 2'd0;
	localparam logic [1:0] MODE_PRIME = 2'd1;
	localparam logic [1:0] MODE_RESET = 2'd2;

	localparam logic [1:0] METH_CONST = 2'd0;
	localparam logic [1:0] METH_MEAS  = 2'd1;
	localparam logic [1:0] METH_SEC   = 2'd2;

	localparam logic [CFG_AW-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [CFG_AW-1:0] REG_OUT_LIMIT  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_STEP_METH  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_TAU_CAP    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_DELAY_DIV  = 3'd5;

	localparam logic [TIME_W-1:0] ONE_Q16    = 32'h0001_0000;
	localparam logic [GAIN_W-1:0] GAIN_FLOOR = 32'd17;
	localparam logic [STEP_W-1:0] STEP_SAT   = {1'b1, {(STEP_W-1){1'b0}}};

	function automatic logic signed [VAL_W-1:0] clamp_lim(
		input logic signed [WIDE_W-1:0] x,
		input logic [LIM_W-1:0]         lim
	);
		logic signed [WIDE_W-1:0] pos;
		logic signed [WIDE_W-1:0] neg;
		pos = signed'({{(WIDE_W-LIM_W){1'b0}}, lim});
		neg = -pos;
		if (x > pos)
			return pos[VAL_W-1:0];
		if (x < neg)
			return neg[VAL_W-1:0];
		return x[VAL_W-1:0];
	endfunction

	function automatic logic reach_lim(
		input logic signed [VAL_W-1:0] x,
		input logic [LIM_W-1:0]        lim
	);
		logic [VAL_W-1:0] m;
		m = x[VAL_W-1] ? VAL_W'(-x) : x;
		return m >= {1'b0, lim};
	endfunction

endpackage
`default_nettype wire

>>> src/pcs_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on pcs_pkg.
`default_nettype none
module pcs_mul import pcs_pkg::*; (
	input  logic                  clk,
	input  logic [GAIN_W-1:0]     a,
	input  logic [GAIN_W-1:0]     b,
	output logic [2*GAIN_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

>>> src/pcs_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated at 2^49.
// Divides the 96-bit product by (delay divisor * 256). Depends on pcs_pkg.
`default_nettype none
module pcs_div import pcs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [TIME_W-1:0]   divisor,
	output logic                done,
	output logic [STEP_W-1:0]   quotient
);

	localparam int DEN_W = TIME_W + 8;
	localparam int CNT_W = $clog2(PROD_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [PROD_W-1:0] dvd_q;
	logic [STEP_W:0]   quo_q;
	logic              sat_q;

	logic [TIME_W-1:0] div_nz;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W:0]    diff;

	assign div_nz = (divisor == '0) ? TIME_W'(1) : divisor;
	assign trial  = {rem_q, dvd_q[PROD_W-1]};
	assign ge     = trial >= {1'b0, den_q};
	assign diff   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				run_q <= 1'b1;
			else if (run_q && cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= CNT_W'(PROD_W - 1);
			den_q <= {div_nz, 8'b0};
			rem_q <= '0;
			dvd_q <= dividend;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			quo_q <= {quo_q[STEP_W-1:0], ge};
			sat_q <= sat_q | quo_q[STEP_W];
		end
	end

	assign done     = done_q;
	assign quotient = (sat_q || quo_q > {1'b0, STEP_SAT}) ? STEP_SAT : quo_q[STEP_W-1:0];

endmodule
`default_nettype wire

>>> src/pi_clock_servo.sv
// PI clock servo top level: configuration registers, sequencer and datapath.
// Depends on pcs_pkg, pcs_mul and pcs_div.
//
// Usage: one input transaction on s_* carries a mode in s_tuser and the offset,
// nominal tau, elapsed time and prime value in s_tdata. Every transaction
// yields exactly one output transaction on m_*: the servo output in m_tdata,
// the at-limit and limit-onset flags in m_tuser.
// A feed passes from acceptance to m_tvalid through five products on the
// shared 32x32 multiplier plus a combine step, the restoring divider (96
// quotient bits, one per cycle, and a done step), two update steps and the
// output step. Prime and reset modes pass through one step of their own
// before the output step; the unused mode goes straight to it. s_tready is
// high only while the sequencer is idle, so one transaction is in flight at
// a time. The result sits in an output register; the next input is taken
// while it waits, and a finished result waits in its final step until
// m_tready frees the register. Configuration writes on cfg_* take effect at
// once; the user must make them while idle, the block does not enforce it.
// Reset clears integral, output, flags and registers (delay divisor to 1.0).
`default_nettype none
module pi_clock_servo import pcs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [LIM_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// offset_ns, nominal_tau, elapsed_time, prime_value
	input  logic [143:0]        s_tdata,
	// mode
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// drive_out
	output logic [VAL_W-1:0]    m_tdata,
	// at_limit, limit_onset
	output logic [1:0]          m_tuser
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'h0001,
		S_CAP   = 13'h0002,
		S_TAU   = 13'h0004,
		S_TK    = 13'h0008,
		S_LO    = 13'h0010,
		S_HI    = 13'h0020,
		S_CMB   = 13'h0040,
		S_DIV   = 13'h0080,
		S_UPD1  = 13'h0100,
		S_UPD2  = 13'h0200,
		S_PRIME = 13'h0400,
		S_CLR   = 13'h0800,
		S_DONE  = 13'h1000
	} state_t;

	state_t state_q, state_n;

	logic [GAIN_W-1:0] kp_q, ki_q;
	logic [LIM_W-1:0]  limit_q;
	logic [1:0]        meth_q;
	logic [TCAP_W-1:0] tcap_q;
	logic [TIME_W-1:0] ddiv_q;

	logic [1:0]              mode_q;
	logic [OFF_W-1:0]        mag_q;
	logic                    neg_q;
	logic [TIME_W-1:0]       nom_q, elap_q, tau_q;
	logic signed [VAL_W-1:0] prime_q;
	logic [55:0]             prop_q;
	logic [GAIN_W-1:0]       tkh_q;
	logic [2*GAIN_W-1:0]     lo_q;
	logic signed [STEP_W:0]  isum_q;
	logic                    onset_q;

	logic signed [VAL_W-1:0] integ_q, drive_q;
	logic                    flag_q, seen_q;

	logic                    m_valid_q;
	logic [VAL_W-1:0]        m_data_q;
	logic [1:0]              m_user_q;

	logic                    acc;
	logic                    out_load;
	logic [GAIN_W-1:0]       mul_a, mul_b;
	logic [2*GAIN_W-1:0]     p_q;
	logic                    div_start, div_done;
	logic [PROD_W-1:0]       dividend;
	logic [STEP_W-1:0]       step;
	logic [GAIN_W-1:0]       kp_f, ki_f;
	logic [TIME_W-1:0]       base, tau_m, tau_n;
	logic [TIME_W+TCAP_W-1:0] cap;
	logic signed [STEP_W:0]  sstep, isum_n;
	logic signed [56:0]      sprop;
	logic signed [WIDE_W-1:0] dsum, clamp_in;
	logic signed [VAL_W-1:0] clamped;
	logic                    now_lim;
	logic [OFF_W-1:0]        off_raw;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_tready);
	assign off_raw  = s_tdata[31:0];

	assign kp_f = (kp_q < GAIN_FLOOR) ? GAIN_FLOOR : kp_q;
	assign ki_f = (ki_q < GAIN_FLOOR) ? GAIN_FLOOR : ki_q;

	// tau selection
	assign cap  = p_q[TIME_W+TCAP_W-1:0];
	assign base = seen_q ? elap_q : ONE_Q16;
	assign tau_m = ({{TCAP_W{1'b0}}, base} > cap) ? cap[TIME_W-1:0] : base;

	always_comb begin
		case (meth_q)
			METH_CONST: tau_n = nom_q;
			METH_MEAS:  tau_n = tau_m;
			default:    tau_n = ONE_Q16;
		endcase
		if (tau_n == '0)
			tau_n = ONE_Q16;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_CAP: begin
				mul_a = {{(GAIN_W-TCAP_W){1'b0}}, tcap_q};
				mul_b = nom_q;
			end
			S_TAU: begin
				mul_a = kp_f;
				mul_b = mag_q;
			end
			S_TK: begin
				mul_a = tau_q;
				mul_b = ki_f;
			end
			S_LO: begin
				mul_a = p_q[GAIN_W-1:0];
				mul_b = mag_q;
			end
			S_HI: begin
				mul_a = tkh_q;
				mul_b = mag_q;
			end
			default: ;
		endcase
	end

	pcs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	assign div_start = (state_q == S_CMB);
	assign dividend  = {p_q, {GAIN_W{1'b0}}} + {{GAIN_W{1'b0}}, lo_q};

	pcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (ddiv_q),
		.done     (div_done),
		.quotient (step)
	);

	assign sstep  = neg_q ? -signed'({1'b0, step}) : signed'({1'b0, step});
	assign isum_n = signed'({{(STEP_W+1-VAL_W){integ_q[VAL_W-1]}}, integ_q}) + sstep;
	assign sprop  = neg_q ? -signed'({1'b0, prop_q}) : signed'({1'b0, prop_q});
	assign dsum   = signed'({sprop[56], sprop})
		+ signed'({{(WIDE_W-STEP_W-1){isum_q[STEP_W]}}, isum_q});

	always_comb begin
		unique case (state_q)
			S_UPD1:  clamp_in = signed'({{(WIDE_W-STEP_W-1){isum_n[STEP_W]}}, isum_n});
			S_UPD2:  clamp_in = dsum;
			S_PRIME: clamp_in = signed'({{(WIDE_W-VAL_W){prime_q[VAL_W-1]}}, prime_q});
			default: clamp_in = signed'({{(WIDE_W-VAL_W){integ_q[VAL_W-1]}}, integ_q});
		endcase
	end

	assign clamped = clamp_lim(clamp_in, limit_q);
	assign now_lim = reach_lim(clamped, limit_q);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (s_tuser)
						MODE_FEED:  state_n = S_CAP;
						MODE_PRIME: state_n = S_PRIME;
						MODE_RESET: state_n = S_CLR;
						default:    state_n = S_DONE;
					endcase
				end
			end
			S_CAP:   state_n = S_TAU;
			S_TAU:   state_n = S_TK;
			S_TK:    state_n = S_LO;
			S_LO:    state_n = S_HI;
			S_HI:    state_n = S_CMB;
			S_CMB:   state_n = S_DIV;
			S_DIV:   if (div_done) state_n = S_UPD1;
			S_UPD1:  state_n = S_UPD2;
			S_UPD2:  state_n = S_DONE;
			S_PRIME: state_n = S_DONE;
			S_CLR:   state_n = S_DONE;
			S_DONE:  if (out_load) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			limit_q <= '0;
			meth_q  <= '0;
			tcap_q  <= '0;
			ddiv_q  <= ONE_Q16;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GAIN_PROP:  kp_q    <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_INTEG: ki_q    <= cfg_wdata[GAIN_W-1:0];
				REG_OUT_LIMIT:  limit_q <= cfg_wdata;
				REG_STEP_METH:  meth_q  <= cfg_wdata[1:0];
				REG_TAU_CAP:    tcap_q  <= cfg_wdata[TCAP_W-1:0];
				REG_DELAY_DIV:  ddiv_q  <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end else if (state_q == S_CLR) begin
			ddiv_q <= ONE_Q16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			drive_q <= '0;
			flag_q  <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_TAU: begin
					integ_q <= clamped;
					if (meth_q == METH_MEAS)
						seen_q <= 1'b1;
				end
				S_UPD1: integ_q <= clamped;
				S_UPD2: begin
					drive_q <= clamped;
					flag_q  <= now_lim;
				end
				S_PRIME: begin
					integ_q <= clamped;
					drive_q <= clamped;
					flag_q  <= now_lim;
				end
				S_CLR: begin
					integ_q <= '0;
					drive_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					mode_q  <= s_tuser;
					neg_q   <= off_raw[OFF_W-1];
					mag_q   <= off_raw[OFF_W-1] ? -off_raw : off_raw;
					nom_q   <= s_tdata[63:32];
					elap_q  <= s_tdata[95:64];
					prime_q <= s_tdata[143:96];
					onset_q <= 1'b0;
				end
			end
			S_TAU:   tau_q   <= tau_n;
			S_TK:    prop_q  <= p_q[63:8];
			S_LO:    tkh_q   <= p_q[2*GAIN_W-1:GAIN_W];
			S_HI:    lo_q    <= p_q;
			S_UPD1:  isum_q  <= isum_n;
			S_UPD2:  onset_q <= now_lim && !flag_q;
			S_PRIME: onset_q <= now_lim && !flag_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= drive_q;
			m_user_q <= {onset_q && (mode_q != MODE_RESET), flag_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule
`default_nettype wire

>>> tb/pi_clock_servo_check.sv
// Checker for the PI clock servo: mirrors the configuration writes, predicts
// each servo result from the accepted input transactions and compares it with
// the result transactions. Depends on pcs_pkg.
module pi_clock_servo_check import pcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [LIM_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [143:0]      s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [VAL_W-1:0]  m_tdata,
	input  logic [1:0]        m_tuser,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint STEP_CAP = longint'(1) << 49;

	typedef struct packed {
		logic [VAL_W-1:0] drive;
		logic             at_lim;
		logic             onset;
	} servo_result_t;

	servo_result_t owed_results[$];

	logic [GAIN_W-1:0] kp_reg, ki_reg;
	logic [LIM_W-1:0]  lim_reg;
	logic [1:0]        meth_reg;
	logic [TCAP_W-1:0] cap_reg;
	logic [TIME_W-1:0] div_reg;
	longint            integ, drive;
	bit                rail_flag, seen_meas;
	int                n_results;

	function automatic longint clip(longint x);
		longint l;
		l = longint'(lim_reg);
		if (x > l)
			return l;
		if (x < -l)
			return -l;
		return x;
	endfunction

	function automatic bit at_rail(longint x);
		longint m;
		m = (x < 0) ? -x : x;
		return m >= longint'(lim_reg);
	endfunction

	// floor(tau * |offset| * ki / (div * 256)), saturated
	function automatic longint integ_increment(logic [31:0] tau, logic [31:0] mag,
			logic [31:0] ki, logic [31:0] div);
		logic [127:0] num, den, q;
		num = 128'(tau) * 128'(ki) * 128'(mag);
		den = 128'((div == 0) ? 32'd1 : div) << 8;
		q = num / den;
		if (q > 128'(STEP_CAP))
			return STEP_CAP;
		return longint'(q[63:0]);
	endfunction

	function automatic servo_result_t servo_update(logic [1:0] mode, logic [143:0] d);
		logic signed [31:0] off;
		logic [31:0]        nom, el, tau, kp, ki, mag;
		logic signed [47:0] prm;
		logic [39:0]        cap;
		longint             step, prop, v;
		bit                 now_rail;
		servo_result_t      r;
		off = d[31:0];
		nom = d[63:32];
		el  = d[95:64];
		prm = d[143:96];
		r.onset = 1'b0;
		case (mode)
			MODE_FEED: begin
				case (meth_reg)
					METH_CONST: tau = nom;
					METH_MEAS: begin
						cap = 40'(cap_reg) * 40'(nom);
						tau = seen_meas ? el : ONE_Q16;
						if ({8'b0, tau} > cap)
							tau = cap[31:0];
						seen_meas = 1'b1;
					end
					default: tau = ONE_Q16;
				endcase
				if (tau == 0)
					tau = ONE_Q16;
				integ = clip(integ);
				kp = (kp_reg < GAIN_FLOOR) ? GAIN_FLOOR : kp_reg;
				ki = (ki_reg < GAIN_FLOOR) ? GAIN_FLOOR : ki_reg;
				mag = off[31] ? 32'(-longint'(off)) : off;
				step = integ_increment(tau, mag, ki, div_reg);
				prop = longint'((64'(kp) * 64'(mag)) >> 8);
				if (off[31]) begin
					step = -step;
					prop = -prop;
				end
				integ = integ + step;
				drive = prop + integ;
				integ = clip(integ);
				drive = clip(drive);
				now_rail = at_rail(drive);
				r.onset = now_rail && !rail_flag;
				rail_flag = now_rail;
			end
			MODE_PRIME: begin
				v = clip(longint'(prm));
				integ = v;
				drive = v;
				now_rail = at_rail(v);
				r.onset = now_rail && !rail_flag;
				rail_flag = now_rail;
			end
			MODE_RESET: begin
				integ = 0;
				drive = 0;
				div_reg = ONE_Q16;
			end
			default: ;
		endcase
		r.drive = drive[47:0];
		r.at_lim = rail_flag;
		return r;
	endfunction

	function automatic void compare_field(string what, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("result %0d: %s expected %h got %h", n_results, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		servo_result_t want;
		if (!arst_n) begin
			kp_reg = '0;
			ki_reg = '0;
			lim_reg = '0;
			meth_reg = METH_CONST;
			cap_reg = '0;
			div_reg = ONE_Q16;
			integ = 0;
			drive = 0;
			rail_flag = 1'b0;
			seen_meas = 1'b0;
			owed_results.delete();
			mismatches = 0;
			outstanding = 0;
			n_results = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_GAIN_PROP:  kp_reg = cfg_wdata[31:0];
					REG_GAIN_INTEG: ki_reg = cfg_wdata[31:0];
					REG_OUT_LIMIT:  lim_reg = cfg_wdata;
					REG_STEP_METH:  meth_reg = cfg_wdata[1:0];
					REG_TAU_CAP:    cap_reg = cfg_wdata[7:0];
					REG_DELAY_DIV:  div_reg = cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				owed_results.push_back(servo_update(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					if (mismatches < 10)
						$display("result %0d: no result was due, got %h", n_results, m_tdata);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					compare_field("drive_out", want.drive, m_tdata);
					compare_field("at_limit", 48'(want.at_lim), 48'(m_tuser[0]));
					compare_field("limit_onset", 48'(want.onset), 48'(m_tuser[1]));
				end
				n_results++;
			end
			outstanding = owed_results.size();
		end
	end

endmodule

>>> tb/pi_clock_servo_test.sv
// Top of the PI clock servo testbench: clock, reset, configuration phases,
// input and output stream traffic and the verdict.
// Depends on pcs_pkg, pi_clock_servo and pi_clock_servo_check.
module pi_clock_servo_test;
	import pcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]       MODE_UNUSED = 2'd3;
	localparam logic [1:0]       METH_UNUSED = 2'd3;
	localparam logic [LIM_W-1:0] LIM_MAX     = 47'h7FFF_FFFF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [LIM_W-1:0]  cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [143:0]      s_tdata = '0;
	logic [1:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [VAL_W-1:0]  m_tdata;
	logic [1:0]        m_tuser;

	int                mismatches, outstanding;
	int                n_sent = 0, n_done = 0;
	bit                rx_hold = 1'b0, quiet = 1'b0;
	logic [LIM_W-1:0]  lim_cur = '0;

	pi_clock_servo DUT (.*);

	pi_clock_servo_check CHK (.*);

	always #4ns clk = ~clk;

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			n_sent <= n_sent + 1;
		if (m_tvalid && m_tready)
			n_done <= n_done + 1;
	end

	initial begin
		#30ms;
		$display("pi_clock_servo: mismatch");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 250);
	endfunction

	function automatic logic [31:0] pick_offset();
		case ($urandom_range(4))
			0: return int'($urandom_range(2000)) - 1000;
			1: return int'($urandom_range(1 << 21)) - (1 << 20);
			2: return $urandom;
			3: return int'($urandom_range(20)) - 10;
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return ONE_Q16;
			2: return 32'($urandom_range(1, 16)) << 16;
			3: return $urandom_range(1, 65535);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] pick_prime();
		case ($urandom_range(4))
			0: return 48'({$urandom, $urandom});
			1: return 48'(longint'(signed'(pick_offset())) <<< 16);
			2: return 48'(longint'(lim_cur) + longint'($urandom_range(4)) - 2);
			3: return 48'(-longint'(lim_cur) + longint'($urandom_range(4)) - 2);
			default: return $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(5))
			0: return $urandom_range(17);
			4: return 32'hFFFF_FFFF;
			5: return $urandom;
			default: return $urandom_range(1 << 20, 1 << 26);
		endcase
	endfunction

	function automatic logic [LIM_W-1:0] pick_limit();
		case ($urandom_range(9))
			0: return '0;
			1: return 47'($urandom_range(1, 1 << 20));
			5: return LIM_MAX;
			6: return 47'({$urandom, $urandom});
			7: return 47'($urandom_range(1, 1000)) << 16;
			default: return 47'($urandom_range(1 << 10, 1 << 26)) << 16;
		endcase
	endfunction

	function automatic logic [31:0] pick_div();
		case ($urandom_range(5))
			0: return 32'd0;
			3: return 32'($urandom_range(1, 16)) << 16;
			4: return $urandom;
			5: return 32'hFFFF_FFFF;
			default: return ONE_Q16;
		endcase
	endfunction

	task automatic write_reg(logic [CFG_AW-1:0] a, logic [LIM_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] kp, logic [31:0] ki, logic [LIM_W-1:0] lim,
			logic [1:0] meth, logic [7:0] cap, logic [31:0] div);
		write_reg(REG_GAIN_PROP, LIM_W'(kp));
		write_reg(REG_GAIN_INTEG, LIM_W'(ki));
		write_reg(REG_OUT_LIMIT, lim);
		write_reg(REG_STEP_METH, LIM_W'(meth));
		write_reg(REG_TAU_CAP, LIM_W'(cap));
		write_reg(REG_DELAY_DIV, LIM_W'(div));
		cfg_we <= 1'b0;
		lim_cur = lim;
	endtask

	// called right after posedge clk; valid stays high into the next transaction unless a gap or settle() comes first
	task automatic offer(logic [1:0] mode, logic [31:0] off, logic [31:0] nom,
			logic [31:0] el, logic [47:0] prm);
		int gap;
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {prm, el, nom, off};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic feed(logic [31:0] off, logic [31:0] nom, logic [31:0] el);
		offer(MODE_FEED, off, nom, el, 48'({$urandom, $urandom}));
	endtask

	task automatic prime(logic [47:0] v);
		offer(MODE_PRIME, $urandom, $urandom, $urandom, v);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (n_done == n_sent);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			feed(pick_offset(), pick_time(), pick_time());
		else if (r < 90)
			prime(pick_prime());
		else if (r < 95)
			offer(MODE_RESET, $urandom, $urandom, $urandom, 48'({$urandom, $urandom}));
		else
			offer(MODE_UNUSED, $urandom, $urandom, $urandom, 48'({$urandom, $urandom}));
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		int run, gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 40);
			repeat (run) begin
				m_tready <= !rx_hold;
				@(posedge clk);
			end
			gap = quiet ? 0 : idle_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		wait (n_sent >= 300);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (900) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// measured tau: first feed uses 1.0, then elapsed, then the cap
		set_config(32'h0100_0000, 32'h0040_0000, 47'(1000) << 16, METH_MEAS, 8'd4, ONE_Q16);
		feed(32'd500, ONE_Q16, 5 * ONE_Q16);
		feed(-32'sd500, ONE_Q16, 2 * ONE_Q16);
		feed(32'd300, ONE_Q16, 10 * ONE_Q16);
		feed(32'd20, 32'd0, ONE_Q16);
		feed(32'd0, ONE_Q16, ONE_Q16);
		feed(32'h7FFF_FFFF, ONE_Q16, ONE_Q16);
		feed(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		prime(48'h7FFF_FFFF_FFFF);
		prime(48'd0);
		prime(48'h8000_0000_0000);
		offer(MODE_UNUSED, $urandom, $urandom, $urandom, 48'd0);
		offer(MODE_RESET, $urandom, $urandom, $urandom, 48'd0);
		feed(-32'sd3, ONE_Q16, ONE_Q16);
		settle();

		// gains below the floor, zero limit, zero divisor
		set_config(32'd0, 32'd0, '0, METH_CONST, 8'd0, 32'd0);
		feed(32'd1000, ONE_Q16, 32'd0);
		feed(-32'sd1, 32'hFFFF_FFFF, 32'd0);
		prime(48'd123);
		offer(MODE_RESET, $urandom, $urandom, $urandom, 48'd0);
		feed(32'd77, ONE_Q16, ONE_Q16);
		settle();

		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, LIM_MAX, METH_SEC, 8'hFF, 32'hFFFF_FFFF);
		feed(32'h7FFF_FFFF, 32'd0, 32'd0);
		feed(-32'sd12345, ONE_Q16, ONE_Q16);
		feed(32'h8000_0000, ONE_Q16, ONE_Q16);
		settle();

		set_config(32'h0100_0000, 32'h0100_0000, 47'd1 << 40, METH_UNUSED, 8'd255, 32'd1);
		feed(32'd1000, 32'd0, 32'd0);
		feed(-32'sd1000, ONE_Q16, ONE_Q16);
		settle();

		for (int p = 0; p < 10; p++) begin
			quiet <= (p % 4 == 1);
			set_config(pick_gain(), pick_gain(), pick_limit(), 2'($urandom_range(3)),
				8'($urandom_range(255)), pick_div());
			repeat (125) random_item();
			settle();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("pi_clock_servo: match");
		else
			$display("pi_clock_servo: mismatch");
		$finish;
	end

endmodule
